// ----- design/md5_pkg.sv -----
// ----------------------------------------------------------------------------
// md5 package
// shared types, round constants, rotate amounts and word-index function
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic       start;
        logic       busy;
    } cmp_ctl_t;

    function automatic word_t step_const(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
            4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
            4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] word_index(input logic [5:0] i);
        logic [3:0] g;
        logic [3:0] n;
        n = i[3:0];
        case (i[5:4])
            2'd0: g = n;
            2'd1: g = 4'((n << 2) + n + 4'd1);
            2'd2: g = 4'((n << 1) + n + 4'd5);
            default: g = 4'((n << 3) - n);
        endcase
        return g;
    endfunction

endpackage

// ----- design/md5_ram.sv -----
// ----------------------------------------------------------------------------
// md5 ram
// generic single-port write, single-port read ram with registered read
// ----------------------------------------------------------------------------
module md5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ----- design/md5_round.sv -----
// ----------------------------------------------------------------------------
// md5 round unit
// one md5 step per cycle while busy, on the a..d working registers, chain add at the end
// ----------------------------------------------------------------------------
module md5_step_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  md5_pkg::cmp_ctl_t   ctl,
    input  logic [5:0]          step,
    input  md5_pkg::word_t      msg_word,
    input  logic                finish,
    input  logic                reinit,
    output md5_pkg::word_t      chain [4]
);
    import md5_pkg::*;

    word_t a_reg, b_reg, c_reg, d_reg;
    word_t chain_reg [4];
    word_t f_val, sum_val, rot_val;
    logic [4:0] s_val;

    always_comb
    begin
        case (step[5:4])
            2'd0: f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum_val = a_reg + f_val + step_const(step) + msg_word;
        s_val = rot_amount(step);
        rot_val = (sum_val << s_val) | (sum_val >> (6'd32 - {1'b0, s_val}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
        end
        else if (reinit)
        begin
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
        end
        else if (finish)
        begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        else if (ctl.busy)
        begin
            a_reg <= d_reg;
            b_reg <= b_reg + rot_val;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
    end

    assign chain = chain_reg;
endmodule

// ----- design/md5_message_digest.sv -----
// ----------------------------------------------------------------------------
// md5 message digest
// byte-serial md5: 64-byte block ram, one round per cycle compression
// ----------------------------------------------------------------------------
// input: a byte is taken whenever the block is idle; a byte filling the block holds the input off
//   while the block is read into the message words, run through the rounds and chain-added
// end of message: padding writes 1 byte per cycle to the block end, then compression;
//   a second padded block follows when the bit count does not fit behind the marker
// throughput: one word at a time, input ready again in the cycle the digest appears
// reset: chaining words to md5 initial values, bit count zero, block ram not cleared
module md5_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [63:0] digest_high,
    output logic [63:0] digest_low,
    output logic        out_valid,
    input  logic        out_ready
);
    import md5_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_ROUND, S_ADD, S_PAD, S_DONE
    } state_t;

    state_t      state_reg;
    logic [63:0] len_reg;
    logic [63:0] fin_len_reg;
    logic        ending_reg;
    logic        len_here_reg;
    logic        marker_done_reg;
    logic        last_reg;
    logic [5:0]  pad_pos_reg;
    logic [6:0]  cnt_reg;
    word_t       w_reg [16];
    logic        out_valid_reg;
    logic [63:0] hi_reg, lo_reg;

    logic        wr_en;
    logic [5:0]  wr_addr, rd_addr;
    logic [7:0]  wr_data, rd_data;
    cmp_ctl_t    ctl;
    logic        finish, reinit;
    word_t       chain [4];
    logic        acc;
    logic [5:0]  step;
    logic [5:0]  ld_byte;
    logic [63:0] len_next;
    logic        marker_now;

    md5_ram #(.WIDTH(8), .DEPTH(64)) u_ram (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    assign step = cnt_reg[5:0];
    md5_step_unit u_round (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .step(step),
        .msg_word(w_reg[word_index(step)]), .finish(finish), .reinit(reinit),
        .chain(chain)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign acc = in_valid && in_ready;
    assign rd_addr = cnt_reg[5:0];
    assign ld_byte = 6'(cnt_reg - 7'd1);
    assign len_next = has_byte ? len_reg + 64'd8 : len_reg;
    assign marker_now = (pad_pos_reg == fin_len_reg[8:3]) && !marker_done_reg;

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = len_reg[8:3];
        wr_data = data_byte;
        if (acc && has_byte)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == S_PAD)
        begin
            wr_en = 1'b1;
            wr_addr = pad_pos_reg;
            if (len_here_reg && pad_pos_reg >= LEN_POS)
                wr_data = fin_len_reg[{pad_pos_reg[2:0], 3'b000} +: 8];
            else if (marker_now)
                wr_data = PAD_BYTE;
            else
                wr_data = 8'h00;
        end
    end

    assign ctl = '{start: (state_reg == S_LOAD) && (cnt_reg == 7'd64),
                   busy: (state_reg == S_ROUND)};
    assign finish    = (state_reg == S_ADD);
    assign reinit    = (state_reg == S_DONE) && !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg <= '0;
            fin_len_reg <= '0;
            ending_reg <= 1'b0;
            len_here_reg <= 1'b0;
            marker_done_reg <= 1'b0;
            last_reg <= 1'b0;
            pad_pos_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        len_reg <= len_next;
                        fin_len_reg <= len_next;
                        ending_reg <= end_of_message;
                        if (has_byte && len_reg[8:3] == 6'd63)
                        begin
                            state_reg <= S_LOAD;
                            cnt_reg <= '0;
                        end
                        else if (end_of_message)
                        begin
                            state_reg <= S_PAD;
                            pad_pos_reg <= len_next[8:3];
                            len_here_reg <= (len_next[8:3] < LEN_POS);
                        end
                    end
                end
                S_LOAD:
                begin
                    if (cnt_reg == 7'd64)
                    begin
                        state_reg <= S_ROUND;
                        cnt_reg <= '0;
                    end
                    else
                        cnt_reg <= cnt_reg + 7'd1;
                end
                S_ROUND:
                begin
                    if (cnt_reg == 7'd63)
                        state_reg <= S_ADD;
                    cnt_reg <= cnt_reg + 7'd1;
                end
                S_ADD:
                begin
                    if (!ending_reg)
                        state_reg <= S_IDLE;
                    else if (last_reg)
                        state_reg <= S_DONE;
                    else
                    begin
                        state_reg <= S_PAD;
                        pad_pos_reg <= '0;
                        len_here_reg <= 1'b1;
                    end
                end
                S_PAD:
                begin
                    pad_pos_reg <= pad_pos_reg + 6'd1;
                    if (marker_now)
                        marker_done_reg <= 1'b1;
                    if (pad_pos_reg == 6'd63)
                    begin
                        state_reg <= S_LOAD;
                        last_reg <= len_here_reg;
                        cnt_reg <= '0;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        for (int k = 0; k < 8; k++)
                        begin
                            hi_reg[63 - 8 * k -: 8] <= chain[k >> 2][8 * (k & 3) +: 8];
                            lo_reg[63 - 8 * k -: 8] <= chain[2 + (k >> 2)][8 * (k & 3) +: 8];
                        end
                        len_reg <= '0;
                        ending_reg <= 1'b0;
                        marker_done_reg <= 1'b0;
                        last_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // byte cnt-1 arrives from the ram in load cycle cnt
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD && cnt_reg != 7'd0)
        begin
            w_reg[ld_byte[5:2]][{ld_byte[1:0], 3'b000} +: 8] <= rd_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign digest_high = hi_reg;
    assign digest_low = lo_reg;
endmodule

// ----- design/md5_checker.sv -----
// ----------------------------------------------------------------------------
// md5 checker
// port-level checks on the digest block
// ----------------------------------------------------------------------------
module md5_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] digest_high,
    input logic [63:0] digest_low
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_high) && $stable(digest_low))
        else $error("digest changed while stalled");
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input word dropped before accept");
    a_digest_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({digest_high, digest_low}))
        else $error("digest unknown while valid");
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("digest after reset");
endmodule

bind md5_message_digest md5_checker u_md5_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_high(digest_high), .digest_low(digest_low)
);
